FILE: hw/rtl/multi_sensor_ranging_poll_sequencer_defines.svh
// assertion macros shared by the sequencer
`ifndef MULTI_SENSOR_RANGING_POLL_SEQUENCER_DEFINES_SVH
`define MULTI_SENSOR_RANGING_POLL_SEQUENCER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MSRPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MSRPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/msrps_pkg.sv
package msrps_pkg;

  localparam int NUM_SENSORS = 5;
  // only this many enable bits exist in the mask register
  localparam int ENABLE_BITS = 5;

  localparam logic [6:0]  ADDR_RESET = 7'h30;
  localparam logic [15:0] REG_STATUS = 16'h004D;
  localparam logic [15:0] REG_START  = 16'h0018;
  localparam logic [15:0] REG_INTR   = 16'h004F;
  localparam logic [15:0] REG_RANGE  = 16'h0062;
  localparam logic [15:0] REG_CLEAR  = 16'h0015;
  localparam logic [7:0]  START_MEAS = 8'h01;
  localparam logic [7:0]  CLEAR_ALL  = 8'h07;

  localparam logic [1:0] ERR_OK  = 2'd0;
  localparam logic [1:0] ERR_BUS = 2'd1;
  localparam logic [1:0] ERR_LEN = 2'd2;

  // configuration register indexes
  localparam logic REG_IDX_ENABLE = 1'b0;
  localparam logic REG_IDX_BASE   = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_INIT    = 3'd0,
    PH_STATUS  = 3'd1,
    PH_STARTED = 3'd2,
    PH_INTR    = 3'd3,
    PH_RANGE   = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       start_round;
    logic       store_byte;
    logic       search_init;
    logic       search_step;
    logic       issue;
    logic       end_round;
    logic       err_set;
    logic [1:0] err;
    logic       query;
    logic       load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic bus_ok;
    logic len_ok;
    logic active;
    logic hit;
    logic last;
    logic out_busy;
  } status_t;

endpackage

FILE: hw/rtl/multi_sensor_ranging_poll_sequencer.sv
// channel  | direction | handshake              | payload
// s_*      | in        | s_tvalid / s_tready    | s_tuser operation, s_tdata event fields
// m_*      | out       | m_tvalid / m_tready    | m_tdata bus command and status
// apb      | in        | psel, penable, pready  | paddr, pwdata, prdata
//
// one word is taken at a time: an execute state, then the round-robin search
// checks one sensor per cycle (1 to NUM_SENSORS sensors), then the result
// goes to the output register through a done state; no search runs for
// ticks in a round, errors, queries, or writes and reads outside a round
// a waiting output word holds the next word in its done state, and the input
// stays closed until that word can load into the output register
// rst is synchronous active high; all sensors come up done, no round running
module multi_sensor_ranging_poll_sequencer #(
  parameter int NUM_SENSORS = msrps_pkg::NUM_SENSORS
) (
  input  logic        clk,
  input  logic        rst,
  // event input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // bus_ok, read_byte, read_length, sensor_index, zero pad
  input  logic [1:0]  s_tuser,   // operation
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // cmd_valid, cmd_write, cmd_device, cmd_register,
                                 // cmd_data, error_code, round_running, distance, zero pad
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "multi_sensor_ranging_poll_sequencer_defines.svh"

  // configuration registers
  logic [4:0] enable_mask;
  logic [6:0] addr_base;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
      addr_base   <= msrps_pkg::ADDR_RESET;
    end else if (cfg_wr) begin
      // register index is the word address, byte offset ignored
      if (paddr[2] == msrps_pkg::REG_IDX_ENABLE) begin
        enable_mask <= pwdata[4:0];
      end else begin
        addr_base <= pwdata[6:0];
      end
    end
  end

  assign prdata = (paddr[2] == msrps_pkg::REG_IDX_BASE) ? {25'd0, addr_base}
                                                        : {27'd0, enable_mask};

  msrps_pkg::cmd_t    cmd;
  msrps_pkg::status_t st;

  msrps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  msrps_dp #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_op       (s_tuser),
    .in_bus_ok   (s_tdata[0]),
    .in_byte     (s_tdata[8:1]),
    .in_len      (s_tdata[16:9]),
    .in_index    (s_tdata[19:17]),
    .enable_mask (enable_mask),
    .addr_base   (addr_base),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata)
  );

  // output word carrying an error code
  logic err_word;
  assign err_word = m_tvalid && (m_tdata[34:33] != msrps_pkg::ERR_OK);

  // a bus command is only issued inside a running round
  `MSRPS_ASSERT_SAME(a_cmd_in_round, m_tvalid && m_tdata[0], m_tdata[35], "command outside round")
  // an error word never carries a bus command
  `MSRPS_ASSERT_SAME(a_err_no_cmd, err_word, !m_tdata[0], "command with error")
  // one word in flight: input closes after an accept
  `MSRPS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accept while busy")

endmodule

FILE: hw/rtl/msrps_ctrl.sv
module msrps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  msrps_pkg::status_t st,
  output msrps_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (st.op)
          msrps_pkg::OP_TICK: begin
            if (!st.active) begin
              cmd.start_round = 1'b1;
              state_next      = S_CHECK;
            end
          end
          msrps_pkg::OP_WRITE: begin
            if (!st.bus_ok) begin
              cmd.err_set = 1'b1;
              cmd.err     = msrps_pkg::ERR_BUS;
            end else if (st.active) begin
              cmd.search_init = 1'b1;
              state_next      = S_CHECK;
            end
          end
          msrps_pkg::OP_READ: begin
            if (!st.len_ok) begin
              cmd.err_set = 1'b1;
              cmd.err     = msrps_pkg::ERR_LEN;
            end else if (st.active) begin
              cmd.store_byte  = 1'b1;
              cmd.search_init = 1'b1;
              state_next      = S_CHECK;
            end
          end
          default: begin
            cmd.query = 1'b1;
          end
        endcase
      end
      S_CHECK: begin
        if (st.hit) begin
          cmd.issue  = 1'b1;
          state_next = S_DONE;
        end else if (st.last) begin
          cmd.end_round = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/msrps_dp.sv
module msrps_dp #(
  parameter int NUM_SENSORS = msrps_pkg::NUM_SENSORS
) (
  input  logic               clk,
  input  logic               rst,
  input  msrps_pkg::cmd_t    cmd,
  output msrps_pkg::status_t st,
  input  logic [1:0]         in_op,
  input  logic               in_bus_ok,
  input  logic [7:0]         in_byte,
  input  logic [7:0]         in_len,
  input  logic [2:0]         in_index,
  input  logic [4:0]         enable_mask,
  input  logic [6:0]         addr_base,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [47:0]        out_data
);

  localparam int SW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int KW = $clog2(NUM_SENSORS + 1);

  function automatic logic [SW-1:0] next_idx(input logic [SW-1:0] i);
    return (i == SW'(NUM_SENSORS - 1)) ? '0 : SW'(i + SW'(1));
  endfunction

  // captured item
  msrps_pkg::op_t op;
  logic           bus_ok;
  logic [7:0]     rbyte;
  logic [7:0]     rlen;
  logic [2:0]     qidx;

  // sequencing state
  logic                  active;
  logic [SW-1:0]         ptr;
  logic [KW-1:0]         cnt;
  msrps_pkg::phase_t     phase    [NUM_SENSORS];
  logic [7:0]            stat_b   [NUM_SENSORS];
  logic [7:0]            intr_b   [NUM_SENSORS];
  logic [7:0]            dist_b   [NUM_SENSORS];

  // result being built
  logic        res_valid;
  logic        res_write;
  logic [6:0]  res_dev;
  logic [15:0] res_reg;
  logic [7:0]  res_data;
  logic [1:0]  res_err;
  logic [7:0]  res_dist;

  logic [7:0]        mask_ext;
  logic              en;
  msrps_pkg::phase_t cur_ph;
  logic              iss_write;
  logic [15:0]       iss_reg;
  logic [7:0]        iss_data;
  msrps_pkg::phase_t iss_ph;
  logic              q_ok;

  assign mask_ext = {3'b000, enable_mask};
  assign en       = (5'(ptr) < 5'(msrps_pkg::ENABLE_BITS)) && mask_ext[3'(ptr)];
  assign cur_ph   = phase[ptr];
  assign q_ok     = (5'(qidx) < 5'(NUM_SENSORS));

  assign st.op       = op;
  assign st.bus_ok   = bus_ok;
  assign st.len_ok   = (rlen == 8'd1);
  assign st.active   = active;
  assign st.hit      = en && (cur_ph != msrps_pkg::PH_DONE);
  assign st.last     = (cnt == KW'(NUM_SENSORS));
  assign st.out_busy = out_valid && !out_ready;

  // command for the selected sensor and its next phase
  always_comb begin
    iss_write = 1'b0;
    iss_reg   = msrps_pkg::REG_STATUS;
    iss_data  = 8'h00;
    iss_ph    = cur_ph;
    case (cur_ph)
      msrps_pkg::PH_INIT: begin
        iss_ph = msrps_pkg::PH_STATUS;
      end
      msrps_pkg::PH_STATUS: begin
        if (stat_b[ptr][0]) begin
          iss_write = 1'b1;
          iss_reg   = msrps_pkg::REG_START;
          iss_data  = msrps_pkg::START_MEAS;
          iss_ph    = msrps_pkg::PH_STARTED;
        end
      end
      msrps_pkg::PH_STARTED: begin
        iss_reg = msrps_pkg::REG_INTR;
        iss_ph  = msrps_pkg::PH_INTR;
      end
      msrps_pkg::PH_INTR: begin
        if (intr_b[ptr][2]) begin
          iss_reg = msrps_pkg::REG_RANGE;
          iss_ph  = msrps_pkg::PH_RANGE;
        end else begin
          iss_reg = msrps_pkg::REG_INTR;
        end
      end
      default: begin
        iss_write = 1'b1;
        iss_reg   = msrps_pkg::REG_CLEAR;
        iss_data  = msrps_pkg::CLEAR_ALL;
        iss_ph    = msrps_pkg::PH_DONE;
      end
    endcase
  end

  // payload capture and result build
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op        <= msrps_pkg::op_t'(in_op);
      bus_ok    <= in_bus_ok;
      rbyte     <= in_byte;
      rlen      <= in_len;
      qidx      <= in_index;
      res_valid <= 1'b0;
      res_write <= 1'b0;
      res_dev   <= '0;
      res_reg   <= '0;
      res_data  <= '0;
      res_err   <= msrps_pkg::ERR_OK;
      res_dist  <= '0;
    end
    if (cmd.err_set) begin
      res_err <= cmd.err;
    end
    if (cmd.query && q_ok) begin
      res_dist <= dist_b[SW'(qidx)];
    end
    if (cmd.issue) begin
      res_valid <= 1'b1;
      res_write <= iss_write;
      res_dev   <= 7'(addr_base + 7'(ptr));
      res_reg   <= iss_reg;
      res_data  <= iss_data;
    end
    if (cmd.load_out) begin
      out_data <= {4'b0000, res_dist, active, res_err, res_data, res_reg, res_dev,
                   res_write, res_valid};
    end
  end

  // sequencing state
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      ptr       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        phase[i]  <= msrps_pkg::PH_DONE;
        stat_b[i] <= '0;
        intr_b[i] <= '0;
        dist_b[i] <= '0;
      end
    end else begin
      if (cmd.start_round) begin
        active <= 1'b1;
        ptr    <= next_idx('0);
        cnt    <= KW'(1);
        for (int i = 0; i < NUM_SENSORS; i++) begin
          phase[i]  <= ((i < msrps_pkg::ENABLE_BITS) && mask_ext[3'(i)]) ?
                       msrps_pkg::PH_INIT : msrps_pkg::PH_DONE;
          stat_b[i] <= '0;
          intr_b[i] <= '0;
        end
      end
      if (cmd.store_byte) begin
        case (cur_ph)
          msrps_pkg::PH_STATUS: stat_b[ptr] <= rbyte;
          msrps_pkg::PH_INTR:   intr_b[ptr] <= rbyte;
          msrps_pkg::PH_RANGE:  dist_b[ptr] <= rbyte;
          default: ;
        endcase
      end
      if (cmd.search_init) begin
        ptr <= next_idx(ptr);
        cnt <= KW'(1);
      end
      if (cmd.search_step) begin
        ptr <= next_idx(ptr);
        cnt <= KW'(cnt + KW'(1));
      end
      if (cmd.issue) begin
        phase[ptr] <= iss_ph;
      end
      if (cmd.end_round) begin
        active <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
